// ===== hdl/extended_euclid_gcd_defines.svh =====
// Assertion macros shared by the extended Euclid GCD RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef EXTENDED_EUCLID_GCD_DEFINES_SVH
`define EXTENDED_EUCLID_GCD_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EEG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("eeg assertion failed");

// Next-cycle implication, disabled while in reset.
`define EEG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("eeg assertion failed");

`endif

// ===== hdl/eeg_pkg.sv =====
// Package for the extended Euclid GCD block: widths, microcode encoding and
// the microcode ROM. No dependencies.
package eeg_pkg;

  localparam int unsigned WIDTH_DEFAULT = 32;
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned PC_W          = 3;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_NO_IN,
    COND_RB_ZERO,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  localparam pc_t PC_ENTRY  = pc_t'(0);
  localparam pc_t PC_TEST   = pc_t'(1);
  localparam pc_t PC_DINIT  = pc_t'(2);
  localparam pc_t PC_DSTEP  = pc_t'(3);
  localparam pc_t PC_UPDATE = pc_t'(4);
  localparam pc_t PC_EMIT   = pc_t'(5);
  localparam pc_t PC_RET    = pc_t'(6);

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_ENTRY:  w = '{op: OP_LOAD,     cond: COND_NO_IN,    target: PC_ENTRY};
      PC_TEST:   w = '{op: OP_NOP,      cond: COND_RB_ZERO,  target: PC_EMIT};
      PC_DINIT:  w = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: PC_ENTRY};
      PC_DSTEP:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: PC_DSTEP};
      PC_UPDATE: w = '{op: OP_UPDATE,   cond: COND_JUMP,     target: PC_TEST};
      PC_EMIT:   w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: PC_EMIT};
      PC_RET:    w = '{op: OP_NOP,      cond: COND_JUMP,     target: PC_ENTRY};
      default:   w = '{op: OP_NOP,      cond: COND_JUMP,     target: PC_ENTRY};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/eeg_in_if.sv =====
// Operand channel: valid/ready handshake carrying a_value and b_value.
// Depends on eeg_pkg for the field width.
interface eeg_in_if;
  logic                        valid;
  logic                        ready;
  logic [eeg_pkg::FIELD_W-1:0] a_value;
  logic [eeg_pkg::FIELD_W-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

// ===== hdl/eeg_out_if.sv =====
// Result channel: valid/ready handshake carrying gcd_value, coef_x, coef_y.
// Depends on eeg_pkg for the field widths.
interface eeg_out_if;
  logic                              valid;
  logic                              ready;
  logic        [eeg_pkg::FIELD_W-1:0] gcd_value;
  logic signed [eeg_pkg::COEF_W-1:0]  coef_x;
  logic signed [eeg_pkg::COEF_W-1:0]  coef_y;

  modport source (output valid, output gcd_value, output coef_x, output coef_y,
                  input ready);
  modport sink   (input valid, input gcd_value, input coef_x, input coef_y,
                  output ready);
endinterface

// ===== hdl/extended_euclid_gcd.sv =====
// Extended Euclid GCD block: microcoded sequencer, coefficient registers and
// result register. Depends on eeg_pkg, eeg_in_if, eeg_out_if, eeg_divider and
// the defines header.
//
// Usage:
//   in_i  carries a_value and b_value; a beat is taken when valid and ready
//         are high at a rising edge. Operands are reduced to their low WIDTH bits.
//   out_o carries gcd_value, coef_x and coef_y, with a*coef_x + b*coef_y = gcd
//         modulo 2^32. One result beat per operand beat, in order.
//   Each division round runs on one shared restoring divider that retires one
//   quotient bit per cycle. At WIDTH = 32 the worst case is 46 rounds; b = 0
//   skips the division rounds and goes straight to the emit step.
//   Items are processed one at a time; in_i.ready is high only at the entry
//   step of the microcode program.
//   A finished result sits in the output register while the next item is
//   accepted and worked on; if the receiver still stalls when that next result
//   is ready, the sequencer holds at its emit step.
//   Reset returns the program counter to the entry step and drops any result
//   still held; the block accepts a beat in the first cycle after reset.
`include "extended_euclid_gcd_defines.svh"

module extended_euclid_gcd #(
  parameter int unsigned WIDTH = eeg_pkg::WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eeg_in_if.sink    in_i,
  eeg_out_if.source out_o
);

  logic [WIDTH-1:0]           ra_q, ra_d, rb_q, rb_d;
  logic [eeg_pkg::COEF_W-1:0] sa_q, sa_d, sb_q, sb_d;
  logic [eeg_pkg::COEF_W-1:0] ta_q, ta_d, tb_q, tb_d;
  eeg_pkg::pc_t               pc_q, pc_d;
  logic                       out_valid_q, out_valid_d;
  logic [eeg_pkg::FIELD_W-1:0] gcd_q, gcd_d;
  logic [eeg_pkg::COEF_W-1:0] cx_q, cx_d, cy_q, cy_d;

  eeg_pkg::ucode_t    uw;
  eeg_pkg::div_ctrl_t div_ctrl;
  logic               taken;
  logic               in_fire;
  logic               out_busy;
  logic               div_more;
  logic [WIDTH-1:0]   div_rem;
  logic [eeg_pkg::COEF_W-1:0] div_ps, div_pt;
  logic [63:0]        a_ext, b_ext, ra_ext;
  logic [WIDTH-1:0]   a_in, b_in;

  assign uw       = eeg_pkg::ucode_rom(pc_q);
  assign a_ext    = 64'(in_i.a_value);
  assign b_ext    = 64'(in_i.b_value);
  assign a_in     = a_ext[WIDTH-1:0];
  assign b_in     = b_ext[WIDTH-1:0];
  assign ra_ext   = 64'(ra_q);
  assign in_i.ready = (uw.op == eeg_pkg::OP_LOAD);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_busy = out_valid_q && !out_o.ready;

  eeg_divider #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (ra_q),
    .divisor_i  (rb_q),
    .sb_i       (sb_q),
    .tb_i       (tb_q),
    .rem_o      (div_rem),
    .ps_o       (div_ps),
    .pt_o       (div_pt),
    .more_o     (div_more)
  );

  always_comb begin
    unique case (uw.cond)
      eeg_pkg::COND_NEXT:     taken = 1'b0;
      eeg_pkg::COND_JUMP:     taken = 1'b1;
      eeg_pkg::COND_NO_IN:    taken = !in_i.valid;
      eeg_pkg::COND_RB_ZERO:  taken = (rb_q == '0);
      eeg_pkg::COND_DIV_MORE: taken = div_more;
      eeg_pkg::COND_OUT_BUSY: taken = out_busy;
      default:                taken = 1'b1;
    endcase
    pc_d = taken ? uw.target : pc_q + eeg_pkg::pc_t'(1);
  end

  always_comb begin
    ra_d        = ra_q;
    rb_d        = rb_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    gcd_d       = gcd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    div_ctrl    = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (uw.op)
      eeg_pkg::OP_NOP: begin
      end
      eeg_pkg::OP_LOAD: begin
        if (in_fire) begin
          ra_d = a_in;
          rb_d = b_in;
          sa_d = eeg_pkg::COEF_W'(1);
          sb_d = '0;
          ta_d = '0;
          tb_d = eeg_pkg::COEF_W'(1);
        end
      end
      eeg_pkg::OP_DIV_INIT: div_ctrl.init = 1'b1;
      eeg_pkg::OP_DIV_STEP: div_ctrl.step = 1'b1;
      eeg_pkg::OP_UPDATE: begin
        ra_d = rb_q;
        rb_d = div_rem;
        sa_d = sb_q;
        sb_d = sa_q - div_ps;
        ta_d = tb_q;
        tb_d = ta_q - div_pt;
      end
      eeg_pkg::OP_EMIT: begin
        if (!out_busy) begin
          gcd_d       = ra_ext[eeg_pkg::FIELD_W-1:0];
          cx_d        = sa_q;
          cy_d        = ta_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= eeg_pkg::PC_ENTRY;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    ta_q  <= ta_d;
    tb_q  <= tb_d;
    gcd_q <= gcd_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.gcd_value = gcd_q;
  assign out_o.coef_x    = cx_q;
  assign out_o.coef_y    = cy_q;

  `EEG_ASSERT_NXT(a_load_takes_operands, clk_i, rst_ni, in_fire,
                  ra_q == $past(a_in) && rb_q == $past(b_in) && pc_q == eeg_pkg::PC_TEST)
  `EEG_ASSERT_IMP(a_emit_at_zero_rem, clk_i, rst_ni, uw.op == eeg_pkg::OP_EMIT,
                  rb_q == '0)
  `EEG_ASSERT_NXT(a_held_result_stays, clk_i, rst_ni, out_busy,
                  out_valid_q && gcd_q == $past(gcd_q) && cx_q == $past(cx_q))
  `EEG_ASSERT_IMP(a_pc_in_program, clk_i, rst_ni, 1'b1, pc_q <= eeg_pkg::PC_RET)

endmodule

// ===== hdl/eeg_divider.sv =====
// Bit-serial restoring divider that also accumulates quotient * sb and
// quotient * tb modulo 2^COEF_W. Depends on eeg_pkg and the defines header.
`include "extended_euclid_gcd_defines.svh"

module eeg_divider #(
  parameter int unsigned WIDTH = eeg_pkg::WIDTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  eeg_pkg::div_ctrl_t         ctrl_i,
  input  logic [WIDTH-1:0]           dividend_i,
  input  logic [WIDTH-1:0]           divisor_i,
  input  logic [eeg_pkg::COEF_W-1:0] sb_i,
  input  logic [eeg_pkg::COEF_W-1:0] tb_i,
  output logic [WIDTH-1:0]           rem_o,
  output logic [eeg_pkg::COEF_W-1:0] ps_o,
  output logic [eeg_pkg::COEF_W-1:0] pt_o,
  output logic                       more_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]           rem_q, rem_d;
  logic [WIDTH-1:0]           dq_q, dq_d;
  logic [eeg_pkg::COEF_W-1:0] ps_q, ps_d;
  logic [eeg_pkg::COEF_W-1:0] pt_q, pt_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [WIDTH:0]             shifted;
  logic [WIDTH:0]             diff;
  logic                       qbit;

  always_comb begin
    shifted = {rem_q, dq_q[WIDTH-1]};
    diff    = shifted - {1'b0, divisor_i};
    qbit    = (shifted >= {1'b0, divisor_i});
    rem_d   = rem_q;
    dq_d    = dq_q;
    ps_d    = ps_q;
    pt_d    = pt_q;
    cnt_d   = cnt_q;
    if (ctrl_i.init) begin
      rem_d = '0;
      dq_d  = dividend_i;
      ps_d  = '0;
      pt_d  = '0;
      cnt_d = CNT_W'(WIDTH);
    end else if (ctrl_i.step) begin
      rem_d = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      dq_d  = {dq_q[WIDTH-2:0], 1'b0};
      ps_d  = {ps_q[eeg_pkg::COEF_W-2:0], 1'b0} + (qbit ? sb_i : '0);
      pt_d  = {pt_q[eeg_pkg::COEF_W-2:0], 1'b0} + (qbit ? tb_i : '0);
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    ps_q  <= ps_d;
    pt_q  <= pt_d;
  end

  assign rem_o  = rem_q;
  assign ps_o   = ps_q;
  assign pt_o   = pt_q;
  assign more_o = (cnt_q != CNT_W'(1));

  `EEG_ASSERT_IMP(a_rem_below_divisor, clk_i, rst_ni, cnt_q != '0, rem_q < divisor_i)
  `EEG_ASSERT_NXT(a_step_counts_down, clk_i, rst_ni, ctrl_i.step && !ctrl_i.init,
                  cnt_q == $past(cnt_q) - CNT_W'(1))
  `EEG_ASSERT_NXT(a_init_loads_count, clk_i, rst_ni, ctrl_i.init, cnt_q == CNT_W'(WIDTH))

endmodule

// ===== verif/extended_euclid_gcd_test.sv =====
// Self-checking testbench for extended_euclid_gcd: operand beats in, gcd and
// Bezout coefficient beats out, checked in order against an internal predictor.
// Depends on eeg_pkg, eeg_in_if, eeg_out_if and the block's RTL.
`timescale 1ns / 100ps

module extended_euclid_gcd_test;

  localparam int unsigned FW          = eeg_pkg::FIELD_W;
  localparam int unsigned CW          = eeg_pkg::COEF_W;
  localparam int unsigned RANDOM_BEATS = 402;
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [FW-1:0] gcd_value;
    logic [CW-1:0] coef_x;
    logic [CW-1:0] coef_y;
  } bezout_t;

  class gcd_scoreboard;
    bezout_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function bezout_t solve_bezout(input logic [FW-1:0] a, input logic [FW-1:0] b);
      bit [63:0] ra, rb, sa, sb, ta, tb, q, rn, sn, tn;
      bezout_t res;
      ra = 64'(a);
      rb = 64'(b);
      sa = 64'd1;
      sb = 64'd0;
      ta = 64'd0;
      tb = 64'd1;
      while (rb != 64'd0) begin
        q  = ra / rb;
        rn = ra - q * rb;
        sn = sa - q * sb;
        tn = ta - q * tb;
        ra = rb;
        rb = rn;
        sa = sb;
        sb = sn;
        ta = tb;
        tb = tn;
      end
      res.gcd_value = ra[FW-1:0];
      res.coef_x    = sa[CW-1:0];
      res.coef_y    = ta[CW-1:0];
      return res;
    endfunction

    function void note_operands(input logic [FW-1:0] a, input logic [FW-1:0] b);
      pending.push_back(solve_bezout(a, b));
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(input logic [FW-1:0] g, input logic [CW-1:0] x,
                      input logic [CW-1:0] y);
      bezout_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result gcd=%0d x=%0d y=%0d",
                                  g, $signed(x), $signed(y)));
      end else begin
        want = pending.pop_front();
        if (g !== want.gcd_value)
          report_mismatch($sformatf("gcd_value %0d, want %0d", g, want.gcd_value));
        if (x !== want.coef_x)
          report_mismatch($sformatf("coef_x %0d, want %0d",
                                    $signed(x), $signed(want.coef_x)));
        if (y !== want.coef_y)
          report_mismatch($sformatf("coef_y %0d, want %0d",
                                    $signed(y), $signed(want.coef_y)));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  longint unsigned cycles;
  logic [FW-1:0] fib[0:47];
  gcd_scoreboard board;

  eeg_in_if  in_if ();
  eeg_out_if out_if ();

  extended_euclid_gcd i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_operands(input logic [FW-1:0] a, input logic [FW-1:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.a_value <= a;
    in_if.b_value <= b;
    do @(posedge clk); while (!in_if.ready);
    board.note_operands(a, b);
  endtask

  task automatic send_random_operands();
    int unsigned pick;
    int unsigned k;
    logic [FW-1:0] g, a, b;
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      a = $urandom();
      b = $urandom();
    end else if (pick < 60) begin
      g = $urandom_range(65535, 1);
      a = g * $urandom_range(65535, 0);
      b = g * $urandom_range(65535, 0);
    end else if (pick < 70) begin
      a = $urandom_range(255, 0);
      b = $urandom_range(255, 0);
    end else if (pick < 78) begin
      a = $urandom();
      b = '0;
      if ($urandom_range(1, 0) == 1) begin
        b = a;
        a = '0;
      end
    end else if (pick < 90) begin
      b = $urandom();
      a = b * $urandom_range(7, 0);
    end else begin
      k = $urandom_range(46, 20);
      a = fib[k+1];
      b = fib[k];
      if ($urandom_range(1, 0) == 1) begin
        a = fib[k];
        b = fib[k+1];
      end
    end
    send_operands(a, b);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_result(out_if.gcd_value, out_if.coef_x, out_if.coef_y);
    out_if.ready <= ($urandom_range(99, 0) >= take_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cycles        = 0;
    in_if.valid   = 1'b0;
    in_if.a_value = '0;
    in_if.b_value = '0;
    out_if.ready  = 1'b0;
    send_idle_pct = 24;
    take_idle_pct = 84;
    board         = new();
    fib[0] = '0;
    fib[1] = 1;
    for (int i = 2; i <= 47; i++)
      fib[i] = fib[i-1] + fib[i-2];

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_operands('0, '0);
    send_operands('0, 1);
    send_operands('0, '1);
    send_operands(1, '0);
    send_operands('1, '0);
    send_operands('1, '1);
    send_operands('1, 1);
    send_operands(1, '1);
    send_operands(1, 1);
    send_operands('1, 32'hFFFF_FFFE);
    send_operands(32'hFFFF_FFFE, '1);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'h8000_0000, 1);
    send_operands(fib[47], fib[46]);
    send_operands(fib[46], fib[47]);
    send_operands(12, 18);
    send_operands(240, 46);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(4096, 6144);
    send_operands(32'hFFFF_FFFB, 32'h7FFF_FFFF);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) begin
        send_idle_pct = 84;
        take_idle_pct <= 24;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        take_idle_pct <= 0;
      end
      send_random_operands();
    end
    in_if.valid <= 1'b0;

    while (board.pending.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
